FILE: src/mmcd_pkg.sv
// Shared types and codes for the coherence directory.
package mmcd_pkg;

  localparam int unsigned ADDR_W = 32;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } mmcd_state_e;

  typedef struct packed {
    logic clr_wr;
    logic rd_en;
    logic load;
    logic commit;
  } mmcd_cmd_t;

  typedef struct packed {
    logic out_busy;
  } mmcd_sts_t;

  localparam logic [1:0] ACT_REG   = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_WRITE = 2'd2;
  localparam logic [1:0] ACT_INV   = 2'd3;

  localparam logic [1:0] LS_I = 2'd0;
  localparam logic [1:0] LS_S = 2'd1;
  localparam logic [1:0] LS_E = 2'd2;
  localparam logic [1:0] LS_M = 2'd3;

  localparam logic [2:0] OC_NONE = 3'd0;
  localparam logic [2:0] OC_HIT  = 3'd1;
  localparam logic [2:0] OC_MRS  = 3'd2;
  localparam logic [2:0] OC_MRE  = 3'd3;
  localparam logic [2:0] OC_MW   = 3'd4;
  localparam logic [2:0] OC_S2M  = 3'd5;
  localparam logic [2:0] OC_E2M  = 3'd6;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_BAD_CORE = 2'd1;
  localparam logic [1:0] STS_FULL     = 2'd2;

endpackage

FILE: src/mmcd_if.sv
// Channel interfaces: request, response and protocol configuration.
interface mmcd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  core;
  logic [31:0] byte_address;
  logic [1:0]  init_state;
  modport source (output valid, action, core, byte_address, init_state, input ready);
  modport sink (input valid, action, core, byte_address, init_state, output ready);
endinterface

interface mmcd_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] line_address;
  logic [2:0]  outcome;
  logic [2:0]  writebacks;
  logic [2:0]  invalidations;
  logic [1:0]  status;
  modport source (output valid, line_address, outcome, writebacks, invalidations, status,
                  input ready);
  modport sink (input valid, line_address, outcome, writebacks, invalidations, status,
                output ready);
endinterface

interface mmcd_cfg_if;
  logic valid;
  logic ready;
  logic protocol_mode;
  modport source (output valid, protocol_mode, input ready);
  modport sink (input valid, protocol_mode, output ready);
endinterface

FILE: src/mmcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mmcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: src/mmcd_ctrl.sv
// Sequencer: clearing pass, table scan, commit and response handoff.
module mmcd_ctrl #(
  parameter int unsigned ENTRIES_PER_CORE = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  mmcd_pkg::mmcd_sts_t                 sts_i,
  output mmcd_pkg::mmcd_cmd_t                 cmd_o,
  output logic [$clog2(ENTRIES_PER_CORE)-1:0] addr_o
);
  import mmcd_pkg::*;

  localparam int unsigned IW = $clog2(ENTRIES_PER_CORE);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES_PER_CORE - 1);

  mmcd_state_e   state_q, state_d;
  logic [IW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = '0;
    case (state_q)
      S_CLEAR: begin
        if (cnt_q == LAST) state_d = S_IDLE;
        else cnt_d = cnt_q + 1'b1;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (cnt_q == LAST) state_d = S_DRAIN;
        else cnt_d = cnt_q + 1'b1;
      end
      S_DRAIN: state_d = S_COMMIT;
      S_COMMIT: begin
        if (!sts_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: cmd_o.clr_wr = 1'b1;
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_SCAN: cmd_o.rd_en = 1'b1;
      S_COMMIT: cmd_o.commit = !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

  assign addr_o = cnt_q;
endmodule

FILE: src/mmcd_dp.sv
// Datapath: per-core tables, scan capture, coherence decision and result register.
module mmcd_dp #(
  parameter int unsigned NUM_CORES        = 2,
  parameter int unsigned LINE_BYTES       = 64,
  parameter int unsigned ENTRIES_PER_CORE = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mmcd_pkg::mmcd_cmd_t                 cmd_i,
  input  logic [$clog2(ENTRIES_PER_CORE)-1:0] addr_i,
  output mmcd_pkg::mmcd_sts_t                 sts_o,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_mode_i,
  input  logic [1:0]                          action_i,
  input  logic [2:0]                          core_i,
  input  logic [31:0]                         byte_address_i,
  input  logic [1:0]                          init_state_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [31:0]                         line_address_o,
  output logic [2:0]                          outcome_o,
  output logic [2:0]                          writebacks_o,
  output logic [2:0]                          invalidations_o,
  output logic [1:0]                          status_o
);
  import mmcd_pkg::*;

  localparam int unsigned IW    = $clog2(ENTRIES_PER_CORE);
  localparam int unsigned OFF_W = $clog2(LINE_BYTES);
  localparam int unsigned TAG_W = ADDR_W - OFF_W;
  localparam int unsigned RW    = 1 + TAG_W + 2;

  logic             mode_q;
  logic [1:0]       act_q;
  logic [2:0]       core_q;
  logic [TAG_W-1:0] tag_q;
  logic [1:0]       init_q;
  logic             rd_v_q;
  logic [IW-1:0]    raddr_q;

  logic             hit_v_q   [NUM_CORES];
  logic [IW-1:0]    hit_idx_q [NUM_CORES];
  logic [1:0]       hit_st_q  [NUM_CORES];
  logic             free_v_q  [NUM_CORES];
  logic [IW-1:0]    free_idx_q[NUM_CORES];

  logic [RW-1:0]    rdata  [NUM_CORES];
  logic             wr_en  [NUM_CORES];
  logic [IW-1:0]    wr_idx [NUM_CORES];
  logic [RW-1:0]    wr_data[NUM_CORES];

  logic             out_v_q;
  logic [TAG_W-1:0] out_tag_q;
  logic [2:0]       out_oc_q, out_wb_q, out_inv_q;
  logic [1:0]       out_sts_q;

  // Decision
  logic       bad, req_hv, req_fv, slot_ok, shared;
  logic [1:0] cur, req_st;
  logic [2:0] n_hit, n_m, outcome, wb_cnt, inv_cnt;
  logic [1:0] status;
  logic       req_wr, inv_en, dn_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_mode_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      core_q <= core_i;
      tag_q  <= byte_address_i[ADDR_W-1:OFF_W];
      init_q <= init_state_i;
    end
    raddr_q <= addr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else begin
      rd_v_q <= cmd_i.rd_en;
    end
  end

  for (genvar c = 0; c < NUM_CORES; c++) begin : g_core
    mmcd_ram #(.WIDTH(RW), .DEPTH(ENTRIES_PER_CORE)) u_ram (
      .clk_i  (clk_i),
      .we_i   (cmd_i.clr_wr | (cmd_i.commit & wr_en[c])),
      .waddr_i(cmd_i.clr_wr ? addr_i : wr_idx[c]),
      .wdata_i(cmd_i.clr_wr ? '0 : wr_data[c]),
      .re_i   (cmd_i.rd_en),
      .raddr_i(addr_i),
      .rdata_o(rdata[c])
    );

    // Keep the first matching entry and the first free entry in index order.
    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        hit_v_q[c]  <= 1'b0;
        free_v_q[c] <= 1'b0;
      end else if (rd_v_q) begin
        if (!hit_v_q[c] && rdata[c][RW-1] && (rdata[c][RW-2:2] == tag_q)) begin
          hit_v_q[c]   <= 1'b1;
          hit_idx_q[c] <= raddr_q;
          hit_st_q[c]  <= rdata[c][1:0];
        end
        if (!free_v_q[c] && !rdata[c][RW-1]) begin
          free_v_q[c]   <= 1'b1;
          free_idx_q[c] <= raddr_q;
        end
      end
    end
  end

  always_comb begin
    bad    = ({1'b0, core_q} >= 4'(NUM_CORES));
    req_hv = 1'b0;
    req_fv = 1'b0;
    cur    = LS_I;
    shared = 1'b0;
    n_hit  = '0;
    n_m    = '0;
    for (int c = 0; c < NUM_CORES; c++) begin
      if (3'(c) == core_q) begin
        req_hv = hit_v_q[c];
        req_fv = free_v_q[c];
        if (hit_v_q[c]) cur = hit_st_q[c];
      end else if (hit_v_q[c]) begin
        n_hit = n_hit + 3'd1;
        if (hit_st_q[c] != LS_I) shared = 1'b1;
        if (hit_st_q[c] == LS_M) n_m = n_m + 3'd1;
      end
    end
    slot_ok = req_hv | req_fv;

    status  = STS_OK;
    outcome = OC_NONE;
    req_wr  = 1'b0;
    req_st  = init_q;
    inv_en  = 1'b0;
    dn_en   = 1'b0;
    if (bad) begin
      status = STS_BAD_CORE;
    end else begin
      case (act_q)
        ACT_REG: begin
          if (slot_ok) req_wr = 1'b1;
          else status = STS_FULL;
        end
        ACT_READ: begin
          if (!mode_q) begin
            if (cur != LS_I) begin
              outcome = OC_HIT;
            end else if (!slot_ok) begin
              status = STS_FULL;
            end else begin
              req_wr = 1'b1;
              if (shared) begin
                dn_en   = 1'b1;
                outcome = OC_MRS;
                req_st  = LS_S;
              end else begin
                outcome = OC_MRE;
                req_st  = LS_E;
              end
            end
          end else begin
            if (cur == LS_S || cur == LS_M) begin
              outcome = OC_HIT;
            end else if (!slot_ok) begin
              status = STS_FULL;
            end else begin
              req_wr  = 1'b1;
              req_st  = LS_S;
              outcome = OC_MRS;
            end
          end
        end
        ACT_WRITE: begin
          req_st = LS_M;
          if (cur == LS_M) begin
            outcome = OC_HIT;
          end else if (!mode_q && cur == LS_E) begin
            req_wr  = 1'b1;
            outcome = OC_E2M;
          end else if (!mode_q && cur == LS_S) begin
            req_wr  = 1'b1;
            inv_en  = 1'b1;
            outcome = OC_S2M;
          end else if (!slot_ok) begin
            status = STS_FULL;
          end else begin
            req_wr  = 1'b1;
            inv_en  = 1'b1;
            outcome = OC_MW;
          end
        end
        ACT_INV: inv_en = 1'b1;
        default: status = STS_OK;
      endcase
    end
    wb_cnt  = dn_en ? n_m : 3'd0;
    inv_cnt = inv_en ? n_hit : 3'd0;
  end

  always_comb begin
    for (int c = 0; c < NUM_CORES; c++) begin
      wr_en[c]   = 1'b0;
      wr_idx[c]  = hit_idx_q[c];
      wr_data[c] = {1'b1, tag_q, LS_S};
      if (3'(c) == core_q) begin
        wr_en[c]   = req_wr;
        wr_idx[c]  = hit_v_q[c] ? hit_idx_q[c] : free_idx_q[c];
        wr_data[c] = {1'b1, tag_q, req_st};
      end else if (inv_en && hit_v_q[c]) begin
        wr_en[c]   = 1'b1;
        wr_data[c] = {1'b0, tag_q, LS_I};
      end else if (dn_en && hit_v_q[c] && (hit_st_q[c] == LS_M || hit_st_q[c] == LS_E)) begin
        wr_en[c] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_tag_q <= tag_q;
      out_oc_q  <= outcome;
      out_wb_q  <= wb_cnt;
      out_inv_q <= inv_cnt;
      out_sts_q <= status;
    end
  end

  assign sts_o.out_busy = out_v_q & ~out_ready_i;
  assign out_valid_o     = out_v_q;
  assign line_address_o  = {out_tag_q, {OFF_W{1'b0}}};
  assign outcome_o       = out_oc_q;
  assign writebacks_o    = out_wb_q;
  assign invalidations_o = out_inv_q;
  assign status_o        = out_sts_q;
endmodule

FILE: src/mesi_msi_coherency_directory_core.sv
// Top level of the MESI/MSI coherence directory.
// Usage:
//   cfg_i  : one-bit protocol word (0 MESI, 1 MSI); always ready, write only while idle.
//   req_i  : one request word (action, core, byte address, initial state).
//   rsp_o  : one result word per request (line address, outcome, write-back and
//            invalidation counts, status).
// Each core owns a table of ENTRIES_PER_CORE entries; all cores' tables are
// scanned side by side, one entry index per cycle.
// From acceptance a request passes through the scan reads of every entry index,
// the drain state that covers the read latency and the commit state, which
// writes the result register. A new request is taken only after the return to
// idle. One request is in flight at a time.
// After reset a clearing pass writes zero to every entry index and empties the
// tables; req_i stays not ready during it.
// A stalled receiver holds the result in the output register; the next request
// may be accepted and scanned meanwhile, and waits at commit until the
// register frees.
module mesi_msi_coherency_directory_core #(
  parameter int unsigned NUM_CORES        = 2,
  parameter int unsigned LINE_BYTES       = 64,
  parameter int unsigned ENTRIES_PER_CORE = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  mmcd_cfg_if.sink   cfg_i,
  mmcd_req_if.sink   req_i,
  mmcd_rsp_if.source rsp_o
);
  import mmcd_pkg::*;

  mmcd_cmd_t                           cmd;
  mmcd_sts_t                           sts;
  logic [$clog2(ENTRIES_PER_CORE)-1:0] addr;
  logic                                in_ready;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = in_ready;

  mmcd_ctrl #(.ENTRIES_PER_CORE(ENTRIES_PER_CORE)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(req_i.valid),
    .in_ready_o(in_ready),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .addr_o    (addr)
  );

  mmcd_dp #(
    .NUM_CORES       (NUM_CORES),
    .LINE_BYTES      (LINE_BYTES),
    .ENTRIES_PER_CORE(ENTRIES_PER_CORE)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .addr_i         (addr),
    .sts_o          (sts),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_mode_i     (cfg_i.protocol_mode),
    .action_i       (req_i.action),
    .core_i         (req_i.core),
    .byte_address_i (req_i.byte_address),
    .init_state_i   (req_i.init_state),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .line_address_o (rsp_o.line_address),
    .outcome_o      (rsp_o.outcome),
    .writebacks_o   (rsp_o.writebacks),
    .invalidations_o(rsp_o.invalidations),
    .status_o       (rsp_o.status)
  );
endmodule
